// ===== rtl/core/dq_pkg.sv =====
package dq_pkg;

   // Field widths of the stream ports
   localparam int unsigned OpWidth      = 2;
   localparam int unsigned ValueWidth   = 32;
   localparam int unsigned StatusWidth  = 2;
   localparam int unsigned OccWidth     = 5;
   localparam int unsigned ReqDataWidth = 32;
   localparam int unsigned RspDataWidth = 40;
   localparam int unsigned WideWidth    = 64;

   typedef enum logic [OpWidth-1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_REAR  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_REAR   = 2'd3
   } op_type;

   typedef enum logic [StatusWidth-1:0] {
      ST_OK        = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_OVERFLOW  = 2'd2
   } status_type;

   // Shift command broadcast to every cell, already qualified by full and empty
   typedef struct packed {
      logic push_front;
      logic push_rear;
      logic pop_front;
      logic pop_rear;
   } cell_cmd_type;

endpackage

// ===== rtl/core/dq_cell.sv =====
module dq_cell
   import dq_pkg::*;
#(
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cell_cmd_type          cmd,
   input  logic [DATA_WIDTH-1:0] push_word,
   input  logic                  left_valid,
   input  logic [DATA_WIDTH-1:0] left_data,
   input  logic                  right_valid,
   input  logic [DATA_WIDTH-1:0] right_data,
   output logic                  valid,
   output logic [DATA_WIDTH-1:0] data,
   output logic [DATA_WIDTH-1:0] tail_word
);

   logic                  valid_ff;
   logic                  valid_in;
   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;
   logic                  is_tail;

   assign is_tail = valid_ff && !right_valid;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      if (cmd.push_front) begin
         // advance the whole row one place toward the rear
         data_in  = left_data;
         valid_in = left_valid;
      end else if (cmd.push_rear) begin
         if (!valid_ff && left_valid) begin
            data_in  = push_word;
            valid_in = 1'b1;
         end
      end else if (cmd.pop_front) begin
         data_in  = right_data;
         valid_in = right_valid;
      end else if (cmd.pop_rear) begin
         if (is_tail) begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign valid     = valid_ff;
   assign data      = data_ff;
   assign tail_word = is_tail ? data_ff : '0;

endmodule

// ===== rtl/core/double_ended_queue.sv =====
// Channel   Dir  Handshake            Payload
// req       in   req_tvalid/tready    tuser: operation; tdata: push_value
// rsp       out  rsp_tvalid/tready    tdata: pop_value, occupancy; tuser: status
//
// One item per cycle while the result is not stalled: each transfer updates the cell row in the same cycle
// and its result is registered, so it appears in the cycle after acceptance.
// Rate is set by the single cell row, which shifts or writes once per item.
// Reset (synchronous) empties the row; stored words are not cleared.
// A stalled result holds; a new request is taken in the cycle it leaves.
module double_ended_queue
   import dq_pkg::*;
#(
   parameter int unsigned DEPTH      = 16,
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [ReqDataWidth-1:0] req_tdata,  // [31:0] push_value
   input  logic [OpWidth-1:0]      req_tuser,  // [1:0] operation
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata,  // [31:0] pop_value, [36:32] occupancy
   output logic [StatusWidth-1:0]  rsp_tuser   // [1:0] status
);

   localparam int unsigned CountWidth = $clog2(DEPTH + 1);

   logic                  accept;
   op_type                op;
   cell_cmd_type          cmd;
   logic                  empty;
   logic                  full;
   logic [WideWidth-1:0]  push_wide;
   logic [DATA_WIDTH-1:0] push_word;
   logic [DATA_WIDTH-1:0] tail_word;
   logic [DATA_WIDTH-1:0] pop_word;
   logic [WideWidth-1:0]  pop_wide;
   logic [WideWidth-1:0]  ones_wide;
   logic [31:0]           count_wide;

   logic [DEPTH-1:0]                 cell_valid;
   logic [DEPTH-1:0][DATA_WIDTH-1:0] cell_data;
   logic [DEPTH-1:0][DATA_WIDTH-1:0] cell_tail;

   logic [CountWidth-1:0]  count_ff;
   logic [CountWidth-1:0]  count_in;
   logic                   rsp_valid_ff;
   logic [ValueWidth-1:0]  value_ff;
   logic [ValueWidth-1:0]  value_in;
   status_type             status_ff;
   status_type             status_in;
   logic [OccWidth-1:0]    occ_ff;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign op         = op_type'(req_tuser);
   assign empty      = !cell_valid[0];
   assign full       = cell_valid[DEPTH-1];

   assign push_wide = WideWidth'(req_tdata);
   assign push_word = push_wide[DATA_WIDTH-1:0];

   always_comb begin
      cmd = '0;
      if (accept) begin
         case (op)
            OP_PUSH_FRONT: cmd.push_front = !full;
            OP_PUSH_REAR:  cmd.push_rear  = !full;
            OP_POP_FRONT:  cmd.pop_front  = !empty;
            OP_POP_REAR:   cmd.pop_rear   = !empty;
            default:       cmd = '0;
         endcase
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                  left_valid;
      logic [DATA_WIDTH-1:0] left_data;
      logic                  right_valid;
      logic [DATA_WIDTH-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_valid = 1'b1;
         assign left_data  = push_word;
      end else begin : g_inner_left
         assign left_valid = cell_valid[i-1];
         assign left_data  = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_valid = 1'b0;
         assign right_data  = '0;
      end else begin : g_inner_right
         assign right_valid = cell_valid[i+1];
         assign right_data  = cell_data[i+1];
      end

      dq_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .push_word   (push_word),
         .left_valid  (left_valid),
         .left_data   (left_data),
         .right_valid (right_valid),
         .right_data  (right_data),
         .valid       (cell_valid[i]),
         .data        (cell_data[i]),
         .tail_word   (cell_tail[i])
      );
   end

   // Only the rear cell drives a nonzero tail word
   always_comb begin
      tail_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         tail_word = tail_word | cell_tail[i];
      end
   end

   assign pop_word  = (op == OP_POP_FRONT) ? cell_data[0] : tail_word;
   assign pop_wide  = WideWidth'(pop_word);
   assign ones_wide = WideWidth'({DATA_WIDTH{1'b1}});

   always_comb begin
      count_in  = count_ff;
      value_in  = '0;
      status_in = ST_OK;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_REAR: begin
            if (full) begin
               status_in = ST_OVERFLOW;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         OP_POP_FRONT, OP_POP_REAR: begin
            if (empty) begin
               status_in = ST_UNDERFLOW;
               value_in  = ones_wide[ValueWidth-1:0];
            end else begin
               count_in = count_ff - 1'b1;
               value_in = pop_wide[ValueWidth-1:0];
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   assign count_wide = 32'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         if (req_tready) begin
            rsp_valid_ff <= accept;
         end
      end
   end

   // Hold the result until its transfer completes
   always_ff @(posedge clock) begin
      if (accept) begin
         value_ff  <= value_in;
         status_ff <= status_in;
         occ_ff    <= count_wide[OccWidth-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RspDataWidth - ValueWidth - OccWidth){1'b0}}, occ_ff, value_ff};
   assign rsp_tuser  = status_ff;

endmodule

// ===== rtl/core/dq_checker.sv =====
module dq_checker
   import dq_pkg::*;
#(
   parameter int unsigned DEPTH = 16
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_tvalid,
   input logic                    req_tready,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic [RspDataWidth-1:0] rsp_tdata,
   input logic [StatusWidth-1:0]  rsp_tuser
);

   localparam logic [31:0] DepthWide = 32'(DEPTH);
   localparam logic [OccWidth-1:0] FullOcc = DepthWide[OccWidth-1:0];

   logic [OccWidth-1:0] occ;
   assign occ = rsp_tdata[36:32];

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("result missing one cycle after request transfer");

   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_UNDERFLOW |-> occ == '0)
      else $error("underflow reported with words held");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_OVERFLOW |-> occ == FullOcc)
      else $error("overflow reported while not full");

endmodule

bind double_ended_queue dq_checker #(.DEPTH(DEPTH)) u_dq_checker (.*);
